### rtl/core/rrsp_pkg.sv
package rrsp_pkg;

	// Parser phases
	typedef enum logic [2:0] {
		PH_TYPE,
		PH_TEXT,
		PH_NUM_FIRST,
		PH_NUM_REST,
		PH_BULK
	} phase_t;

	// Item types opened by a type byte
	typedef enum logic [2:0] {
		IT_NONE,
		IT_ERROR,
		IT_STATUS,
		IT_INTEGER,
		IT_BULK,
		IT_ARRAY
	} item_t;

	// Event kinds
	localparam logic [3:0] EV_PAYLOAD    = 4'd0;
	localparam logic [3:0] EV_STATUS_END = 4'd1;
	localparam logic [3:0] EV_ERROR_END  = 4'd2;
	localparam logic [3:0] EV_INTEGER    = 4'd3;
	localparam logic [3:0] EV_BULK_START = 4'd4;
	localparam logic [3:0] EV_BULK_END   = 4'd5;
	localparam logic [3:0] EV_NIL        = 4'd6;
	localparam logic [3:0] EV_ARRAY      = 4'd7;
	localparam logic [3:0] EV_FAULT      = 4'd8;

	// Fault codes
	localparam logic [1:0] FLT_NONE      = 2'd0;
	localparam logic [1:0] FLT_BAD_TYPE  = 2'd1;
	localparam logic [1:0] FLT_TOO_DEEP  = 2'd2;
	localparam logic [1:0] FLT_TOO_LARGE = 2'd3;

	// Protocol bytes
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Largest bulk length whose byte count still fits 33 bits
	localparam logic [63:0] BULK_LEN_MAX = 64'h0000_0001_ffff_fffd;

	// Received byte with its classification
	typedef struct packed {
		logic [7:0] data;
		logic       digit;
		logic       cr;
		logic       lf;
	} cls_t;

	// One result event
	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  data;
		logic [63:0] value;
		logic [3:0]  depth;
		logic        done;
		logic [1:0]  fault;
		logic        last;
	} event_t;

endpackage

### rtl/core/resp_reply_stream_parser.sv
// Streaming parser for RESP2 replies. Bytes enter through a two-entry queue
// (push/full), and a byte is taken every clock while the four-entry event
// queue (empty/pop) has room for two more events; one byte yields at most
// two events, the last one carrying last. A close that pops several finished
// arrays is settled in the same cycle by a search over the MAX_DEPTH stack
// levels. After a protocol fault every later byte is consumed silently until
// reset.
module resp_reply_stream_parser
	import rrsp_pkg::*;
#(
	parameter int MAX_DEPTH  = 8,
	parameter int COUNT_BITS = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  event_kind,
	output logic [7:0]  data_byte,
	output logic signed [63:0] value,
	output logic [3:0]  depth,
	output logic        reply_done,
	output logic [1:0]  fault_code,
	output logic        last
);

	logic       cls_valid;
	cls_t       cls_item;
	logic       cls_take;
	logic       room;
	logic [1:0] ev_count;
	event_t     ev0;
	event_t     ev1;
	event_t     head;

	rrsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.cls_valid (cls_valid),
		.cls_item  (cls_item),
		.cls_take  (cls_take)
	);

	rrsp_exec #(
		.MAX_DEPTH  (MAX_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls_item  (cls_item),
		.cls_take  (cls_take),
		.out_room  (room),
		.ev_count  (ev_count),
		.ev0       (ev0),
		.ev1       (ev1)
	);

	rrsp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_count (ev_count),
		.ev0      (ev0),
		.ev1      (ev1),
		.room     (room),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign event_kind = head.kind;
	assign data_byte  = head.data;
	assign value      = head.value;
	assign depth      = head.depth;
	assign reply_done = head.done;
	assign fault_code = head.fault;
	assign last       = head.last;

endmodule

### rtl/core/rrsp_front.sv
module rrsp_front
	import rrsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       cls_valid,
	output cls_t       cls_item,
	input  logic       cls_take
);

	cls_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;
	cls_t       cls_new;

	// Classify the incoming byte
	always_comb begin
		cls_new.data  = rx_byte;
		cls_new.digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		cls_new.cr    = (rx_byte == CH_CR);
		cls_new.lf    = (rx_byte == CH_LF);
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full;
	assign cls_valid = (cnt_q != 2'd0);
	assign rd        = cls_take && cls_valid;
	assign cls_item  = mem_q[rp_q];

	// Store classified bytes
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cls_new;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

### rtl/core/rrsp_exec.sv
module rrsp_exec
	import rrsp_pkg::*;
#(
	parameter int MAX_DEPTH  = 8,
	parameter int COUNT_BITS = 32
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cls_valid,
	input  cls_t       cls_item,
	output logic       cls_take,
	input  logic       out_room,
	output logic [1:0] ev_count,
	output event_t     ev0,
	output event_t     ev1
);

	localparam int SP_W  = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	phase_t            phase_q, phase_d;
	item_t             type_q, type_d;
	logic              cr_q, cr_d;
	logic [63:0]       acc_q, acc_d;
	logic              sign_q, sign_d;
	logic              bad_q, bad_d;
	logic              closed_q, closed_d;
	logic [32:0]       bulk_q, bulk_d;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic              err_q, err_d;
	logic [COUNT_BITS-1:0] rem_q [MAX_DEPTH];
	logic [MAX_DEPTH-1:0]  one_q;

	logic              fire;
	logic [7:0]        b;
	logic [3:0]        dep;
	logic              found;
	logic [IDX_W-1:0]  top_idx;
	logic              close_en;
	logic              push_en;
	logic [63:0]       num_v;
	logic [32:0]       bulk_dec;
	logic [63:0]       acc_x10;
	event_t            e0, e1;
	logic [1:0]        n;

	assign fire     = cls_valid && out_room;
	assign cls_take = fire;
	assign b        = cls_item.data;
	assign dep      = 4'(sp_q);
	assign acc_x10  = (acc_q << 3) + (acc_q << 1) + {56'd0, b - CH_ZERO};
	assign bulk_dec = bulk_q - 33'd1;

	// Decode the finished number
	always_comb begin
		if (bad_q) begin
			num_v = '1;
		end else if (sign_q) begin
			num_v = 64'd0 - acc_q;
		end else begin
			num_v = acc_q;
		end
	end

	// Search the stack for the innermost level that stays open after a close
	always_comb begin
		found   = 1'b0;
		top_idx = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((SP_W'(i) < sp_q) && !one_q[i]) begin
				found   = 1'b1;
				top_idx = IDX_W'(i);
			end
		end
	end

	// Step the parser by one byte
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		cr_d     = cr_q;
		acc_d    = acc_q;
		sign_d   = sign_q;
		bad_d    = bad_q;
		closed_d = closed_q;
		bulk_d   = bulk_q;
		err_d    = err_q;
		close_en = 1'b0;
		push_en  = 1'b0;
		e0       = '0;
		e1       = '0;
		n        = 2'd0;
		e0.depth = dep;
		e1.depth = dep;
		if (fire && !err_q) begin
			unique case (phase_q)
				PH_TYPE: begin
					cr_d     = 1'b0;
					acc_d    = '0;
					sign_d   = 1'b0;
					bad_d    = 1'b0;
					closed_d = 1'b0;
					unique case (b)
						CH_MINUS: begin
							type_d  = IT_ERROR;
							phase_d = PH_TEXT;
						end
						CH_PLUS: begin
							type_d  = IT_STATUS;
							phase_d = PH_TEXT;
						end
						CH_COLON: begin
							type_d  = IT_INTEGER;
							phase_d = PH_NUM_FIRST;
						end
						CH_DOLLAR: begin
							type_d  = IT_BULK;
							phase_d = PH_NUM_FIRST;
						end
						CH_STAR: begin
							if (sp_q >= SP_W'(MAX_DEPTH)) begin
								err_d    = 1'b1;
								e0.kind  = EV_FAULT;
								e0.fault = FLT_TOO_DEEP;
								n        = 2'd1;
							end else begin
								type_d  = IT_ARRAY;
								phase_d = PH_NUM_FIRST;
							end
						end
						default: begin
							err_d    = 1'b1;
							e0.kind  = EV_FAULT;
							e0.fault = FLT_BAD_TYPE;
							n        = 2'd1;
						end
					endcase
				end
				PH_TEXT: begin
					if (cr_q) begin
						if (cls_item.lf) begin
							cr_d     = 1'b0;
							phase_d  = PH_TYPE;
							e0.kind  = (type_q == IT_ERROR) ? EV_ERROR_END : EV_STATUS_END;
							e0.done  = !found;
							close_en = 1'b1;
							n        = 2'd1;
						end else begin
							e0.kind = EV_PAYLOAD;
							e0.data = CH_CR;
							n       = 2'd1;
							if (!cls_item.cr) begin
								cr_d    = 1'b0;
								e1.kind = EV_PAYLOAD;
								e1.data = b;
								n       = 2'd2;
							end
						end
					end else if (cls_item.cr) begin
						cr_d = 1'b1;
					end else begin
						e0.kind = EV_PAYLOAD;
						e0.data = b;
						n       = 2'd1;
					end
				end
				PH_NUM_FIRST: begin
					phase_d = PH_NUM_REST;
					if (cls_item.cr) begin
						closed_d = 1'b1;
						cr_d     = 1'b1;
					end else if (b == CH_MINUS) begin
						sign_d = 1'b1;
					end else if (cls_item.digit) begin
						acc_d = {56'd0, b - CH_ZERO};
					end else if (b != CH_PLUS) begin
						bad_d = 1'b1;
					end
				end
				PH_NUM_REST: begin
					if (cr_q && cls_item.lf) begin
						phase_d = PH_TYPE;
						cr_d    = 1'b0;
						e0.value = num_v;
						n        = 2'd1;
						if (type_q == IT_INTEGER) begin
							e0.kind  = EV_INTEGER;
							e0.done  = !found;
							close_en = 1'b1;
						end else if (type_q == IT_BULK) begin
							if (num_v[63]) begin
								e0.kind  = EV_NIL;
								e0.done  = !found;
								close_en = 1'b1;
							end else if (num_v > BULK_LEN_MAX) begin
								err_d    = 1'b1;
								e0.kind  = EV_FAULT;
								e0.fault = FLT_TOO_LARGE;
								e0.value = '0;
							end else begin
								bulk_d  = num_v[32:0] + 33'd2;
								phase_d = PH_BULK;
								e0.kind = EV_BULK_START;
							end
						end else begin
							if (num_v == '1) begin
								e0.kind  = EV_NIL;
								e0.done  = !found;
								close_en = 1'b1;
							end else if (num_v[63] || (num_v == '0)) begin
								e0.kind  = EV_ARRAY;
								e0.done  = !found;
								close_en = 1'b1;
							end else if ((sp_q >= SP_W'(MAX_DEPTH))
								|| (num_v[63:COUNT_BITS] != '0)) begin
								err_d    = 1'b1;
								e0.kind  = EV_FAULT;
								e0.fault = (sp_q >= SP_W'(MAX_DEPTH)) ?
									FLT_TOO_DEEP : FLT_TOO_LARGE;
								e0.value = '0;
							end else begin
								e0.kind = EV_ARRAY;
								push_en = 1'b1;
							end
						end
					end else begin
						cr_d = cls_item.cr;
						if (cls_item.cr) begin
							closed_d = 1'b1;
						end else if (!closed_q && !bad_q) begin
							if (cls_item.digit) begin
								acc_d = acc_x10;
							end else begin
								bad_d = 1'b1;
							end
						end
					end
				end
				PH_BULK: begin
					if (bulk_q > 33'd2) begin
						e0.kind = EV_PAYLOAD;
						e0.data = b;
						n       = 2'd1;
					end
					bulk_d = bulk_dec;
					if (bulk_dec == '0) begin
						phase_d  = PH_TYPE;
						e0.kind  = EV_BULK_END;
						e0.data  = '0;
						e0.done  = !found;
						close_en = 1'b1;
						n        = 2'd1;
					end
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase
		end
		// Mark the final event of this byte
		if (n == 2'd1) begin
			e0.last = 1'b1;
		end else if (n == 2'd2) begin
			e1.last = 1'b1;
		end
	end

	// Close or open stack levels
	always_comb begin
		sp_d = sp_q;
		if (close_en) begin
			sp_d = found ? SP_W'(top_idx) + SP_W'(1) : '0;
		end else if (push_en) begin
			sp_d = sp_q + SP_W'(1);
		end
	end

	assign ev_count = n;
	assign ev0      = e0;
	assign ev1      = e1;

	// Hold level counts
	always_ff @(posedge clk) begin
		if (close_en && found) begin
			rem_q[top_idx] <= rem_q[top_idx] - COUNT_BITS'(1);
			one_q[top_idx] <= (rem_q[top_idx] == COUNT_BITS'(2));
		end else if (push_en) begin
			rem_q[sp_q[IDX_W-1:0]] <= num_v[COUNT_BITS-1:0];
			one_q[sp_q[IDX_W-1:0]] <= (num_v[COUNT_BITS-1:0] == COUNT_BITS'(1));
		end
	end

	// Hold number accumulator and remaining bulk byte count
	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		bulk_q <= bulk_d;
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			type_q   <= IT_NONE;
			cr_q     <= 1'b0;
			sign_q   <= 1'b0;
			bad_q    <= 1'b0;
			closed_q <= 1'b0;
			sp_q     <= '0;
			err_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			cr_q     <= cr_d;
			sign_q   <= sign_d;
			bad_q    <= bad_d;
			closed_q <= closed_d;
			sp_q     <= sp_d;
			err_q    <= err_d;
		end
	end

endmodule

### rtl/core/rrsp_outq.sv
module rrsp_outq
	import rrsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] ev_count,
	input  event_t     ev0,
	input  event_t     ev1,
	output logic       room,
	output logic       empty,
	input  logic       pop,
	output event_t     head
);

	event_t     mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       rd;

	assign room  = (cnt_q <= 3'd2);
	assign empty = (cnt_q == 3'd0);
	assign rd    = pop && !empty;
	assign head  = mem_q[rp_q];

	// Write up to two events
	always_ff @(posedge clk) begin
		if (ev_count != 2'd0) begin
			mem_q[wp_q] <= ev0;
		end
		if (ev_count == 2'd2) begin
			mem_q[wp_q + 2'd1] <= ev1;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + ev_count;
			if (rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, ev_count} - {2'b00, rd};
		end
	end

endmodule

### tb/reply_checker.sv
module reply_checker
	import rrsp_pkg::*;
#(
	parameter int MAX_DEPTH  = 8,
	parameter int COUNT_BITS = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [3:0]  event_kind,
	input  logic [7:0]  data_byte,
	input  logic [63:0] value,
	input  logic [3:0]  depth,
	input  logic        reply_done,
	input  logic [1:0]  fault_code,
	input  logic        last,
	output int          fails,
	output int          pending
);

	event_t event_q[$];
	event_t byte_events[$];

	// Parser state
	phase_t                ph;
	item_t                 itm;
	logic                  cr_held;
	logic [63:0]           acc;
	logic                  neg_sign, bad_num, num_closed;
	logic [32:0]           bulk_left;
	logic [COUNT_BITS-1:0] lvl [MAX_DEPTH];
	int unsigned           sp;
	logic                  halted;

	initial fails = 0;

	function automatic void emit(logic [3:0] k, logic [7:0] d, logic [63:0] v,
		logic [3:0] dep, logic dn, logic [1:0] f);
		event_t e;
		e.kind  = k;
		e.data  = d;
		e.value = v;
		e.depth = dep;
		e.done  = dn;
		e.fault = f;
		e.last  = 1'b0;
		byte_events.insert(byte_events.size(), e);
	endfunction

	// Count one element off the open arrays; true when the whole reply is done
	function automatic logic close_level();
		while (sp > 0) begin
			lvl[sp-1] = lvl[sp-1] - 1'b1;
			if (lvl[sp-1] != 0)
				return 1'b0;
			sp--;
		end
		return 1'b1;
	endfunction

	function automatic void raise_fault(logic [1:0] code);
		halted = 1'b1;
		emit(EV_FAULT, 8'd0, 64'd0, sp[3:0], 1'b0, code);
	endfunction

	function automatic void finish(logic [3:0] k, logic [63:0] v);
		logic [3:0] dep;
		logic       dn;
		dep = sp[3:0];
		dn  = close_level();
		emit(k, 8'd0, v, dep, dn, FLT_NONE);
	endfunction

	function automatic void end_number();
		logic [63:0] v;
		if (bad_num)
			v = '1;
		else if (neg_sign)
			v = -acc;
		else
			v = acc;
		ph      = PH_TYPE;
		cr_held = 1'b0;
		if (itm == IT_INTEGER) begin
			finish(EV_INTEGER, v);
		end else if (itm == IT_BULK) begin
			if (v[63]) begin
				finish(EV_NIL, v);
			end else if (v > BULK_LEN_MAX) begin
				raise_fault(FLT_TOO_LARGE);
			end else begin
				bulk_left = v[32:0] + 33'd2;
				ph = PH_BULK;
				emit(EV_BULK_START, 8'd0, v, sp[3:0], 1'b0, FLT_NONE);
			end
		end else if (v == '1) begin
			finish(EV_NIL, v);
		end else if (v[63] || v == 0) begin
			finish(EV_ARRAY, v);
		end else if ((v >> COUNT_BITS) != 0 || sp >= MAX_DEPTH) begin
			raise_fault(sp >= MAX_DEPTH ? FLT_TOO_DEEP : FLT_TOO_LARGE);
		end else begin
			emit(EV_ARRAY, 8'd0, v, sp[3:0], 1'b0, FLT_NONE);
			lvl[sp] = v[COUNT_BITS-1:0];
			sp++;
		end
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// Advance the parser by one byte and queue the events it causes
	function automatic void parse_byte(logic [7:0] b);
		byte_events.delete();
		if (halted)
			return;
		case (ph)
			PH_TYPE: begin
				case (b)
					CH_MINUS: begin itm = IT_ERROR; ph = PH_TEXT; end
					CH_PLUS: begin itm = IT_STATUS; ph = PH_TEXT; end
					CH_COLON: begin itm = IT_INTEGER; ph = PH_NUM_FIRST; end
					CH_DOLLAR: begin itm = IT_BULK; ph = PH_NUM_FIRST; end
					CH_STAR: begin
						if (sp >= MAX_DEPTH) begin
							raise_fault(FLT_TOO_DEEP);
						end else begin
							itm = IT_ARRAY;
							ph = PH_NUM_FIRST;
						end
					end
					default: raise_fault(FLT_BAD_TYPE);
				endcase
				cr_held = 1'b0;
				acc = '0;
				neg_sign = 1'b0;
				bad_num = 1'b0;
				num_closed = 1'b0;
			end
			PH_TEXT: begin
				if (cr_held) begin
					if (b == CH_LF) begin
						cr_held = 1'b0;
						ph = PH_TYPE;
						finish(itm == IT_ERROR ? EV_ERROR_END : EV_STATUS_END, 64'd0);
					end else begin
						emit(EV_PAYLOAD, CH_CR, 64'd0, sp[3:0], 1'b0, FLT_NONE);
						if (b != CH_CR) begin
							cr_held = 1'b0;
							emit(EV_PAYLOAD, b, 64'd0, sp[3:0], 1'b0, FLT_NONE);
						end
					end
				end else if (b == CH_CR) begin
					cr_held = 1'b1;
				end else begin
					emit(EV_PAYLOAD, b, 64'd0, sp[3:0], 1'b0, FLT_NONE);
				end
			end
			PH_NUM_FIRST: begin
				ph = PH_NUM_REST;
				if (b == CH_CR) begin
					num_closed = 1'b1;
					cr_held = 1'b1;
				end else if (b == CH_MINUS) begin
					neg_sign = 1'b1;
				end else if (b == CH_PLUS) begin
				end else if (is_digit(b)) begin
					acc = {56'd0, b - CH_ZERO};
				end else begin
					bad_num = 1'b1;
				end
			end
			PH_NUM_REST: begin
				if (cr_held && b == CH_LF) begin
					end_number();
				end else begin
					cr_held = (b == CH_CR);
					if (b == CH_CR)
						num_closed = 1'b1;
					else if (!num_closed && !bad_num) begin
						if (is_digit(b))
							acc = acc * 64'd10 + {56'd0, b - CH_ZERO};
						else
							bad_num = 1'b1;
					end
				end
			end
			default: begin
				if (bulk_left > 2)
					emit(EV_PAYLOAD, b, 64'd0, sp[3:0], 1'b0, FLT_NONE);
				if (bulk_left > 0)
					bulk_left = bulk_left - 1'b1;
				if (bulk_left == 0) begin
					ph = PH_TYPE;
					finish(EV_BULK_END, 64'd0);
				end
			end
		endcase
		if (byte_events.size() > 0)
			byte_events[byte_events.size()-1].last = 1'b1;
		foreach (byte_events[i])
			event_q.insert(event_q.size(), byte_events[i]);
	endfunction

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			fails++;
		end
	endfunction

	// Compare each event transfer, then predict from each byte transfer
	always @(posedge clk or negedge arst_n) begin
		event_t e;
		if (!arst_n) begin
			ph = PH_TYPE;
			itm = IT_NONE;
			cr_held = 1'b0;
			acc = '0;
			neg_sign = 1'b0;
			bad_num = 1'b0;
			num_closed = 1'b0;
			bulk_left = '0;
			sp = 0;
			halted = 1'b0;
			event_q.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (event_q.size() == 0) begin
					$error("event with none expected: kind %0d", event_kind);
					fails++;
				end else begin
					e = event_q[0];
					event_q.delete(0);
					check_field("event_kind", e.kind, event_kind);
					check_field("data_byte", e.data, data_byte);
					check_field("value", e.value, value);
					check_field("depth", e.depth, depth);
					check_field("reply_done", e.done, reply_done);
					check_field("fault_code", e.fault, fault_code);
					check_field("last", e.last, last);
				end
			end
			if (push && !full)
				parse_byte(rx_byte);
			pending <= event_q.size();
		end
	end

endmodule

### tb/testbench.sv
module testbench
	import rrsp_pkg::*;
();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        pop = 1'b0;
	logic        full, empty, reply_done, last;
	logic [3:0]  event_kind, depth;
	logic [7:0]  data_byte;
	logic signed [63:0] value;
	logic [1:0]  fault_code;
	int          fails, pending;
	logic        calm = 1'b0;
	int          pop_wait = 0;
	logic [7:0]  stream_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	resp_reply_stream_parser u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .event_kind(event_kind), .data_byte(data_byte),
		.value(value), .depth(depth), .reply_done(reply_done),
		.fault_code(fault_code), .last(last)
	);

	reply_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .event_kind(event_kind), .data_byte(data_byte),
		.value(value), .depth(depth), .reply_done(reply_done),
		.fault_code(fault_code), .last(last), .fails(fails), .pending(pending)
	);

	// Stall the event side a random number of cycles after each transfer
	always @(posedge clk) begin
		if (pop && !empty)
			pop_wait = calm ? 0 : $urandom_range(0, 9);
		else if (pop_wait > 0)
			pop_wait--;
		pop <= (pop_wait == 0);
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	task automatic put_byte(logic [7:0] x);
		stream_q.insert(stream_q.size(), x);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// Close a number line, sometimes with an ignored byte after the first CR
	task automatic end_line();
		logic [7:0] j;
		if ($urandom_range(0, 4) == 0) begin
			j = 8'($urandom_range(0, 255));
			if (j == CH_LF)
				j = CH_PLUS;
			put_byte(CH_CR);
			put_byte(j);
		end
		put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	function automatic string number_text();
		logic [63:0] r;
		logic [7:0]  j;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return $sformatf("%0d", $signed(r));
			1: return $sformatf("%0d", r);
			2: return $sformatf("%0d", $urandom_range(0, 99));
			3: return $sformatf("-%0d", $urandom_range(0, 99));
			4: return $sformatf("+%0d", $urandom_range(0, 99));
			5: return "";
			6: begin
				do j = 8'($urandom_range(33, 126)); while (j >= CH_ZERO && j <= CH_NINE);
				return $sformatf("%0d%c%0d", $urandom_range(0, 9), j, $urandom_range(0, 9));
			end
			7: return "-9223372036854775808";
			8: return "9223372036854775807";
			default: return "--1";
		endcase
	endfunction

	// Append one random item; arrays recurse up to max_lvl levels
	task automatic gen_item(int lvl, int max_lvl);
		logic [7:0] b, prev;
		int n;
		case ($urandom_range(0, 5))
			0, 1: begin
				put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				prev = 8'd0;
				repeat ($urandom_range(0, 6)) begin
					b = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 7) == 0)
						b = CH_CR;
					if (prev == CH_CR && b == CH_LF)
						b = CH_ZERO;
					put_byte(b);
					prev = b;
				end
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			2: begin
				put_byte(CH_COLON);
				put_text(number_text());
				end_line();
			end
			3: begin
				put_byte(CH_DOLLAR);
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 2))
						0: put_text("-1");
						1: put_text("-7");
						default: put_text("x2");
					endcase
					end_line();
				end else begin
					n = $urandom_range(0, 8);
					put_text($sformatf("%0d", n));
					end_line();
					repeat (n)
						put_byte(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 3) == 0) begin
						put_byte(8'($urandom_range(0, 255)));
						put_byte(8'($urandom_range(0, 255)));
					end else begin
						put_byte(CH_CR);
						put_byte(CH_LF);
					end
				end
			end
			default: begin
				put_byte(CH_STAR);
				if (lvl < max_lvl) begin
					n = (lvl < 2) ? $urandom_range(1, 3) :
						(max_lvl > 3 ? 1 : $urandom_range(1, 2));
					put_text($sformatf("%0d", n));
					end_line();
					repeat (n)
						gen_item(lvl + 1, max_lvl);
				end else begin
					case ($urandom_range(0, 2))
						0: put_text("0");
						1: put_text("-1");
						default: put_text("-4");
					endcase
					end_line();
				end
			end
		endcase
	endtask

	// Hold off a random gap, then present the byte until it transfers
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_stream();
		logic [7:0] b;
		while (stream_q.size() > 0) begin
			b = stream_q[0];
			stream_q.delete(0);
			send_byte(b);
		end
	endtask

	initial begin
		int sent;
		int paused;
		sent = 0;
		paused = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed replies: text with stray CRs, number extremes, nil and empty arrays
		put_text("+OK\r\n-a\rb\r\r\r");
		put_byte(8'h00);
		put_byte(8'hff);
		put_text("\r\n:-9223372036854775808\r\n:+18446744073709551616\r\n:\r\n:1a\r\n");
		put_text(":5\rzz\r\n$3\r\nabc\r\n$-1\r\n$0\r\n\r\n*-1\r\n*0\r\n*-2\r\n");
		put_text("*2\r\n:1\r\n$1\r\n");
		put_byte(8'hff);
		put_text("\r\n");
		repeat (8) put_text("*1\r\n");
		put_text(":5\r\n");
		drain_stream();

		// Random replies, occasionally nested seven levels deep
		while (sent < 1900) begin
			calm = ($urandom_range(0, 7) == 0);
			gen_item(0, ($urandom_range(0, 5) == 0) ? 7 : 3);
			sent += stream_q.size();
			drain_stream();
			if (!paused && sent > 950) begin
				paused = 1;
				push <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
		end
		calm = 1'b0;

		// End on one sticky fault, then bytes that must be dropped silently
		case ($urandom_range(0, 2))
			0: put_byte($urandom_range(0, 1) ? 8'h00 : 8'hff);
			1: begin
				repeat (8) put_text("*2\r\n");
				put_byte(CH_STAR);
			end
			default: put_text($urandom_range(0, 1) ? "*4294967296\r\n" : "$8589934590\r\n");
		endcase
		put_text("+ok\r\n:7\r\n");
		drain_stream();
		push <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/rrsp_pkg.sv
rtl/core/rrsp_front.sv
rtl/core/rrsp_exec.sv
rtl/core/rrsp_outq.sv
rtl/core/resp_reply_stream_parser.sv
tb/reply_checker.sv
tb/testbench.sv
